@@ rtl/hsvrgb_pkg.sv @@
`default_nettype none

package hsvrgb_pkg;

    localparam int FRAC_BITS_DEF = 8;

    // field widths of the stream payloads
    localparam int HUE_W    = 17;
    localparam int SAT_W    = 9;
    localparam int VAL_W    = 9;
    localparam int CHAN_W   = 8;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    localparam int SECTOR_DEG   = 60;
    localparam int SECTOR_COUNT = 6;
    localparam int CHAN_MAX     = 255;
    localparam int UNIT_ONE     = 256;

    // reciprocal of 60 with 16 fraction bits, rounded down
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_60    = 1092;

    // pre-division channel value is below 256 * 60 when not saturated
    localparam int Y_W = 14;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t sector;
        logic    gray;
    } hsvrgb_ctl_t;

    typedef struct packed {
        hsvrgb_ctl_t        ctl;
        logic [CHAN_W-1:0]  cv;
        logic [CHAN_W-1:0]  cm;
        logic               neg;
        logic               sat;
        logic [Y_W-1:0]     y;
        logic [CHAN_W-1:0]  q0;
    } hsvrgb_res_t;

    function automatic logic [CHAN_W-1:0] clamp8(input logic [CHAN_W:0] x);
        return (x > (CHAN_W+1)'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : x[CHAN_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/hsvrgb_sector.sv @@
`default_nettype none

module hsvrgb_sector #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          ce,
    input  wire logic [hsvrgb_pkg::HUE_W-1:0]  hue,
    input  wire logic [hsvrgb_pkg::SAT_W-1:0]  saturation,
    input  wire logic [hsvrgb_pkg::VAL_W-1:0]  brightness,
    output hsvrgb_pkg::hsvrgb_ctl_t            ctl,
    output logic [FRAC_BITS+5:0]               fn,
    output logic [hsvrgb_pkg::SAT_W-1:0]       sat,
    output logic [hsvrgb_pkg::VAL_W-1:0]       val
);
    import hsvrgb_pkg::*;

    localparam int HW = (FRAC_BITS + 9 > HUE_W) ? FRAC_BITS + 9 : HUE_W;
    localparam int DW = FRAC_BITS + 6;
    localparam logic [HW-1:0] HMAX = HW'(SECTOR_DEG * SECTOR_COUNT) << FRAC_BITS;
    localparam logic [DW-1:0] DSEC = DW'(SECTOR_DEG) << FRAC_BITS;

    logic [HW-1:0]   h_ext;
    logic [HW-1:0]   h_clip;
    logic [8:0]      deg;
    logic [8:0]      base_deg;
    sector_t         sector;
    logic [DW-1:0]   rem;

    hsvrgb_ctl_t     ctl_reg, ctl_next;
    logic [DW-1:0]   fn_reg, fn_next;
    logic [SAT_W-1:0] sat_reg;
    logic [VAL_W-1:0] val_reg;

    always_comb begin
        h_ext  = HW'(hue);
        h_clip = (h_ext > HMAX) ? HMAX : h_ext;
        deg    = 9'(h_clip >> FRAC_BITS);
    end

    // full circle folds onto the first sector with zero remainder
    always_comb begin
        priority if (deg >= 9'd360) begin
            sector = SEC_R_Y;  base_deg = 9'd360;
        end else if (deg >= 9'd300) begin
            sector = SEC_M_R;  base_deg = 9'd300;
        end else if (deg >= 9'd240) begin
            sector = SEC_B_M;  base_deg = 9'd240;
        end else if (deg >= 9'd180) begin
            sector = SEC_C_B;  base_deg = 9'd180;
        end else if (deg >= 9'd120) begin
            sector = SEC_G_C;  base_deg = 9'd120;
        end else if (deg >= 9'd60) begin
            sector = SEC_Y_G;  base_deg = 9'd60;
        end else begin
            sector = SEC_R_Y;  base_deg = 9'd0;
        end
    end

    always_comb begin
        rem              = DW'(h_clip - (HW'(base_deg) << FRAC_BITS));
        // fraction runs backward on even sectors
        fn_next          = sector[0] ? rem : DSEC - rem;
        ctl_next.sector  = sector;
        ctl_next.gray    = (hue == '0) && (saturation == '0);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl_reg <= ctl_next;
            fn_reg  <= fn_next;
            sat_reg <= saturation;
            val_reg <= brightness;
        end
    end

    assign ctl = ctl_reg;
    assign fn  = fn_reg;
    assign sat = sat_reg;
    assign val = val_reg;

endmodule

`default_nettype wire

@@ rtl/hsvrgb_chan.sv @@
`default_nettype none

module hsvrgb_chan #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          ce,
    input  wire hsvrgb_pkg::hsvrgb_ctl_t       ctl,
    input  wire logic [FRAC_BITS+5:0]          fn,
    input  wire logic [hsvrgb_pkg::SAT_W-1:0]  sat,
    input  wire logic [hsvrgb_pkg::VAL_W-1:0]  val,
    output hsvrgb_pkg::hsvrgb_res_t            res
);
    import hsvrgb_pkg::*;

    localparam int DW  = FRAC_BITS + 6;
    localparam int PW  = DW + SAT_W;
    localparam int AW  = FRAC_BITS + 14;
    localparam int XW  = AW + VAL_W;
    localparam int XSW = XW + 8;
    localparam logic [AW-1:0] FULL = AW'(SECTOR_DEG) << (FRAC_BITS + 8);

    // stage 2: s * fn, v * (1 - s), v channel
    hsvrgb_ctl_t       ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic [PW-1:0]     p_reg, p_next;
    logic [16:0]       pm_reg, pm_next;
    logic [SAT_W-1:0]  one_minus_s;
    logic [16:0]       cv_prod;
    logic [CHAN_W-1:0] cv2_reg, cv3_reg, cv4_reg, cv5_reg, cv_next;
    logic [VAL_W-1:0]  v2_reg, v3_reg;

    always_comb begin
        p_next      = PW'(sat) * PW'(fn);
        one_minus_s = SAT_W'(UNIT_ONE) - sat;
        // saturation above one clamps the m channel to zero
        pm_next     = (sat > SAT_W'(UNIT_ONE)) ? '0 : 17'(val) * 17'(one_minus_s);
        cv_prod     = 17'(val) * 17'(CHAN_MAX);
        cv_next     = clamp8(cv_prod[16:8]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl2_reg <= ctl;
            p_reg    <= p_next;
            pm_reg   <= pm_next;
            cv2_reg  <= cv_next;
            v2_reg   <= val;
        end
    end

    // stage 3: 1 - s*f and m channel
    logic [AW-1:0]     a_reg, a_next;
    logic              neg3_reg, neg4_reg, neg5_reg, neg_next;
    logic [24:0]       cm_prod;
    logic [CHAN_W-1:0] cm3_reg, cm4_reg, cm5_reg, cm_next;

    always_comb begin
        neg_next = p_reg >= PW'(FULL);
        a_next   = AW'(PW'(FULL) - p_reg);
        cm_prod  = 25'(pm_reg) * 25'(CHAN_MAX);
        cm_next  = clamp8(cm_prod[24:16]);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl3_reg <= ctl2_reg;
            cv3_reg  <= cv2_reg;
            v3_reg   <= v2_reg;
            a_reg    <= a_next;
            neg3_reg <= neg_next;
            cm3_reg  <= cm_next;
        end
    end

    // stage 4: v * (1 - s*f)
    logic [XW-1:0] x_reg, x_next;

    assign x_next = XW'(v3_reg) * XW'(a_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl4_reg <= ctl3_reg;
            cv4_reg  <= cv3_reg;
            cm4_reg  <= cm3_reg;
            neg4_reg <= neg3_reg;
            x_reg    <= x_next;
        end
    end

    // stage 5: scale by 255 and drop the fraction, still 60 times too large
    logic [XSW-1:0] xs;
    logic [14:0]    y_full;
    logic [Y_W-1:0] y5_reg;
    logic           sat5_reg, sat_next;

    always_comb begin
        xs       = XSW'(x_reg) * XSW'(CHAN_MAX);
        y_full   = 15'(xs >> (16 + FRAC_BITS));
        sat_next = y_full >= 15'(UNIT_ONE * SECTOR_DEG);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl5_reg <= ctl4_reg;
            cv5_reg  <= cv4_reg;
            cm5_reg  <= cm4_reg;
            neg5_reg <= neg4_reg;
            sat5_reg <= sat_next;
            y5_reg   <= y_full[Y_W-1:0];
        end
    end

    // stage 6: quotient estimate by 60, at most one low
    hsvrgb_res_t    res_reg, res_next;
    logic [24:0]    q_prod;

    always_comb begin
        q_prod       = 25'(y5_reg) * 25'(RECIP_60);
        res_next.ctl = ctl5_reg;
        res_next.cv  = cv5_reg;
        res_next.cm  = cm5_reg;
        res_next.neg = neg5_reg;
        res_next.sat = sat5_reg;
        res_next.y   = y5_reg;
        res_next.q0  = CHAN_W'(q_prod >> RECIP_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

@@ rtl/hsv_to_rgb.sv @@
// channel  | dir | ports                          | payload
// s_       | in  | s_tvalid s_tready s_tdata[39:0] | hue, saturation, brightness
// m_       | out | m_tvalid m_tready m_tdata[23:0] | red, green, blue
//
// one pixel per clock while the output side is not stalled
// stages: sector split, three product stages, scale, divide-by-60 estimate,
// correction and channel select into the output register
// aresetn clears only the valid bits; payload registers are not reset
// a stalled result holds the whole pipeline, so s_tready follows the output side
`default_nettype none

module hsv_to_rgb #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // hue[16:0], saturation[25:17], brightness[34:26], zero fill
    input  wire logic [hsvrgb_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [hsvrgb_pkg::M_DATA_W-1:0]       m_tdata
);
    import hsvrgb_pkg::*;

    localparam int STAGES = 6;

    logic               ce;
    logic [STAGES-1:0]  vld_reg;
    logic               out_vld_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    hsvrgb_ctl_t        ctl1;
    logic [FRAC_BITS+5:0] fn1;
    logic [SAT_W-1:0]   sat1;
    logic [VAL_W-1:0]   val1;
    hsvrgb_res_t        res;

    assign ce = !out_vld_reg || m_tready;

    hsvrgb_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
        .aclk       (aclk),
        .ce         (ce),
        .hue        (s_tdata[HUE_W-1:0]),
        .saturation (s_tdata[HUE_W+SAT_W-1:HUE_W]),
        .brightness (s_tdata[HUE_W+SAT_W+VAL_W-1:HUE_W+SAT_W]),
        .ctl        (ctl1),
        .fn         (fn1),
        .sat        (sat1),
        .val        (val1)
    );

    hsvrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
        .aclk (aclk),
        .ce   (ce),
        .ctl  (ctl1),
        .fn   (fn1),
        .sat  (sat1),
        .val  (val1),
        .res  (res)
    );

    // finish the divide by 60 and order the channels
    logic [Y_W-1:0]     q60;
    logic [Y_W-1:0]     rem;
    logic [CHAN_W-1:0]  q;
    logic [CHAN_W-1:0]  cn;
    logic [CHAN_W-1:0]  rr, gg, bb;

    always_comb begin
        q60 = Y_W'(res.q0) * Y_W'(SECTOR_DEG);
        rem = res.y - q60;
        q   = res.q0 + CHAN_W'(rem >= Y_W'(SECTOR_DEG));
        cn  = res.neg ? '0 : (res.sat ? CHAN_W'(CHAN_MAX) : q);
    end

    always_comb begin
        if (res.ctl.gray) begin
            rr = res.cv;  gg = res.cv;  bb = res.cv;
        end else begin
            unique case (res.ctl.sector)
                SEC_Y_G: begin rr = cn;     gg = res.cv; bb = res.cm; end
                SEC_G_C: begin rr = res.cm; gg = res.cv; bb = cn;     end
                SEC_C_B: begin rr = res.cm; gg = cn;     bb = res.cv; end
                SEC_B_M: begin rr = cn;     gg = res.cm; bb = res.cv; end
                SEC_M_R: begin rr = res.cv; gg = res.cm; bb = cn;     end
                default: begin rr = res.cv; gg = cn;     bb = res.cm; end
            endcase
        end
        out_data_next = {bb, gg, rr};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg     <= {vld_reg[STAGES-2:0], s_tvalid};
            out_vld_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= out_data_next;
        end
    end

    assign s_tready = ce;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/hsvrgb_check.sv @@
`default_nettype none

module hsvrgb_check (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [hsvrgb_pkg::M_DATA_W-1:0]  m_tdata
);

    // a held result keeps its value until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side is ready exactly when the output register can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output side");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // nothing accepted while the pipeline runs free through all its stages leaves no result
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!(s_tvalid && s_tready), 7) && $past(!(s_tvalid && s_tready), 6)
        && $past(!(s_tvalid && s_tready), 5) && $past(!(s_tvalid && s_tready), 4)
        && $past(!(s_tvalid && s_tready), 3) && $past(!(s_tvalid && s_tready), 2)
        && $past(!(s_tvalid && s_tready), 1)
        && $past(s_tready, 7) && $past(s_tready, 1) && $past(aresetn, 7)
        |-> !m_tvalid || !$past(s_tready, 2) || !$past(s_tready, 3)
            || !$past(s_tready, 4) || !$past(s_tready, 5) || !$past(s_tready, 6))
        else $error("result without request");

endmodule

bind hsv_to_rgb hsvrgb_check u_hsvrgb_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
